@@ rtl/core/zip_stored_archive_writer_defines.svh @@
// Assertion macros for the stored ZIP archive writer.
// Used by the back end, which checks its own sequencing.
`ifndef ZIP_STORED_ARCHIVE_WRITER_DEFINES_SVH
`define ZIP_STORED_ARCHIVE_WRITER_DEFINES_SVH

// same-cycle implication
`define ZSAW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ZSAW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/zsaw_pkg.sv @@
// Shared types, constants and the CRC-32 byte step for the ZIP archive writer.
// No dependencies.
package zsaw_pkg;

   localparam logic [2:0] MODE_NAME   = 3'd0;
   localparam logic [2:0] MODE_DATA   = 3'd1;
   localparam logic [2:0] MODE_END    = 3'd2;
   localparam logic [2:0] MODE_FINISH = 3'd3;
   localparam logic [2:0] MODE_PULL   = 3'd4;

   localparam logic CSR_DOS_TIME = 1'b0;
   localparam logic CSR_DOS_DATE = 1'b1;

   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [31:0] SIG_LOCAL   = 32'h0403_4b50;
   localparam logic [31:0] SIG_CENTRAL = 32'h0201_4b50;
   localparam logic [31:0] SIG_END     = 32'h0605_4b50;
   localparam logic [15:0] ZIP_VERSION = 16'd20;
   localparam logic [15:0] DATE_RESET  = 16'h0021;
   localparam int LOCAL_LEN   = 30;
   localparam int CENTRAL_LEN = 46;
   localparam int END_LEN     = 22;
   localparam int Q_DEPTH     = 4;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       archive_end;
      logic       dropped;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NAME,
      OP_DATA,
      OP_END,
      OP_FINISH,
      OP_PULL
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  value;
   } op_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] r;
      r = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

@@ rtl/core/zsaw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module zsaw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/zsaw_front.sv @@
// Front end: accepts requests, classifies the mode and queues operations.
// Depends on zsaw_pkg.
module zsaw_front
   import zsaw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    op_valid,
   output op_type  op_data,
   input  logic    op_pop
);

   localparam int PW = $clog2(Q_DEPTH);
   localparam int CNTW = $clog2(Q_DEPTH + 1);

   op_type          q_ff [Q_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   op_type          op_new;
   logic            known;
   logic            push;

   always_comb begin
      op_new.value = req_data.in_byte;
      op_new.kind  = OP_PULL;
      known        = 1'b1;
      case (req_data.mode)
         MODE_NAME:   op_new.kind = OP_NAME;
         MODE_DATA:   op_new.kind = OP_DATA;
         MODE_END:    op_new.kind = OP_END;
         MODE_FINISH: op_new.kind = OP_FINISH;
         MODE_PULL:   op_new.kind = OP_PULL;
         default:     known = 1'b0;
      endcase
   end

   assign req_stall = (count_ff == CNTW'(Q_DEPTH));
   assign push      = req_valid && !req_stall && known;
   assign op_valid  = (count_ff != '0);
   assign op_data   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + PW'(1)) : wr_ptr_ff;
      rd_ptr_in = op_pop ? PW'(rd_ptr_ff + PW'(1)) : rd_ptr_ff;
      count_in  = CNTW'(count_ff + CNTW'(push) - CNTW'(op_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

@@ rtl/core/zsaw_back.sv @@
// Back end: executes queued operations, owns the byte stores, the directory,
// the CRC and the output sequencer. Depends on zsaw_pkg, zsaw_ram, defines.
`include "zip_stored_archive_writer_defines.svh"
module zsaw_back
   import zsaw_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int DATA_BYTES  = 4096,
   parameter int NAME_BYTES  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] dos_time,
   input  logic [15:0] dos_date,
   input  logic        op_valid,
   input  op_type      op_data,
   output logic        op_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int DA   = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
   localparam int DW   = $clog2(DATA_BYTES + 1);
   localparam int NA   = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
   localparam int NLW  = $clog2(NAME_BYTES + 1);
   localparam int EA   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int ECW  = $clog2(MAX_ENTRIES + 1);
   localparam int BIGB = (DATA_BYTES > NAME_BYTES) ? DATA_BYTES : NAME_BYTES;
   localparam int MAXLEN = (BIGB > CENTRAL_LEN) ? BIGB : CENTRAL_LEN;
   localparam int CW   = $clog2(MAXLEN + 1);

   typedef struct packed {
      logic [31:0]    crc;
      logic [DW-1:0]  size;
      logic [NLW-1:0] start;
      logic [NLW-1:0] len;
      logic [31:0]    offset;
   } dir_entry_type;

   localparam int DIRW = $bits(dir_entry_type);

   typedef enum logic [2:0] {
      ST_OP, ST_PULL, ST_SKIP, ST_DIRRD, ST_DIRLD
   } state_type;

   typedef enum logic [2:0] {
      PH_IDLE, PH_LHDR, PH_LNAME, PH_LDATA, PH_CHDR, PH_CNAME, PH_END
   } phase_type;

   state_type      state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic [CW-1:0]  cursor_ff, cursor_in;
   logic [EA-1:0]  emit_entry_ff, emit_entry_in;
   logic [ECW-1:0] entry_count_ff, entry_count_in;
   logic [DW-1:0]  data_count_ff, data_count_in;
   logic [NLW-1:0] name_fill_ff, name_fill_in;
   logic [NLW-1:0] name_mark_ff, name_mark_in;
   logic [31:0]    crc_ff, crc_in;
   logic [31:0]    bytes_ff, bytes_in;
   logic [31:0]    cd_size_ff, cd_size_in;
   logic [31:0]    cd_off_ff, cd_off_in;
   logic           error_ff, error_in;
   dir_entry_type  cur_ff, cur_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           data_we, name_we, dir_we;
   logic [7:0]     data_q, name_q;
   dir_entry_type  dir_wdata;
   logic [DIRW-1:0] dir_q;
   logic           busy, can_take;
   logic [CW-1:0]  plen, cursor_inc;
   logic           last;
   logic [7:0]     out_b;
   phase_type      adv_phase;
   logic           adv_clear, adv_entry;
   logic [7:0]     lh [LOCAL_LEN];
   logic [7:0]     ch [CENTRAL_LEN];
   logic [7:0]     eh [END_LEN];
   logic [31:0]    size32;
   logic [15:0]    len16, ecnt16;

   zsaw_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_data_ram (
      .clock(clock), .we(data_we), .waddr(DA'(data_count_ff)), .wdata(op_data.value),
      .raddr(cursor_ff[DA-1:0]), .rdata(data_q)
   );

   zsaw_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_name_ram (
      .clock(clock), .we(name_we), .waddr(NA'(name_fill_ff)), .wdata(op_data.value),
      .raddr(NA'(32'(cur_ff.start) + 32'(cursor_ff))), .rdata(name_q)
   );

   zsaw_ram #(.WIDTH(DIRW), .DEPTH(MAX_ENTRIES)) u_dir_ram (
      .clock(clock), .we(dir_we), .waddr(EA'(entry_count_ff)), .wdata(dir_wdata),
      .raddr(emit_entry_ff), .rdata(dir_q)
   );

   assign busy     = (phase_ff != PH_IDLE);
   assign can_take = !(op_data.kind == OP_PULL && busy && rsp_valid_ff && rsp_stall);
   assign cursor_inc = CW'(cursor_ff + CW'(1));
   assign last     = (phase_ff == PH_END) && (cursor_ff == CW'(END_LEN - 1));

   always_comb begin
      case (phase_ff)
         PH_LHDR:  plen = CW'(LOCAL_LEN);
         PH_LNAME: plen = CW'(cur_ff.len);
         PH_LDATA: plen = CW'(cur_ff.size);
         PH_CHDR:  plen = CW'(CENTRAL_LEN);
         PH_CNAME: plen = CW'(cur_ff.len);
         PH_END:   plen = CW'(END_LEN);
         default:  plen = '0;
      endcase
   end

   always_comb begin
      adv_clear = 1'b0;
      adv_entry = 1'b0;
      case (phase_ff)
         PH_LHDR:  adv_phase = PH_LNAME;
         PH_LNAME: adv_phase = PH_LDATA;
         PH_LDATA: begin
            adv_phase = PH_IDLE;
            adv_clear = 1'b1;
         end
         PH_CHDR:  adv_phase = PH_CNAME;
         PH_CNAME: begin
            if ((ECW'(emit_entry_ff) + ECW'(1)) < entry_count_ff) begin
               adv_phase = PH_CHDR;
               adv_entry = 1'b1;
            end else begin
               adv_phase = PH_END;
            end
         end
         default:  adv_phase = PH_IDLE;
      endcase
   end

   // header images
   always_comb begin
      size32 = 32'(cur_ff.size);
      len16  = 16'(cur_ff.len);
      ecnt16 = 16'(entry_count_ff);
      lh = '{default: 8'h00};
      ch = '{default: 8'h00};
      eh = '{default: 8'h00};
      for (int k = 0; k < 4; k++) begin
         lh[k]      = SIG_LOCAL[8*k +: 8];
         lh[14 + k] = cur_ff.crc[8*k +: 8];
         lh[18 + k] = size32[8*k +: 8];
         lh[22 + k] = size32[8*k +: 8];
         ch[k]      = SIG_CENTRAL[8*k +: 8];
         ch[16 + k] = cur_ff.crc[8*k +: 8];
         ch[20 + k] = size32[8*k +: 8];
         ch[24 + k] = size32[8*k +: 8];
         ch[42 + k] = cur_ff.offset[8*k +: 8];
         eh[k]      = SIG_END[8*k +: 8];
         eh[12 + k] = cd_size_ff[8*k +: 8];
         eh[16 + k] = cd_off_ff[8*k +: 8];
      end
      for (int k = 0; k < 2; k++) begin
         lh[4 + k]  = ZIP_VERSION[8*k +: 8];
         lh[10 + k] = dos_time[8*k +: 8];
         lh[12 + k] = dos_date[8*k +: 8];
         lh[26 + k] = len16[8*k +: 8];
         ch[4 + k]  = ZIP_VERSION[8*k +: 8];
         ch[6 + k]  = ZIP_VERSION[8*k +: 8];
         ch[12 + k] = dos_time[8*k +: 8];
         ch[14 + k] = dos_date[8*k +: 8];
         ch[28 + k] = len16[8*k +: 8];
         eh[8 + k]  = ecnt16[8*k +: 8];
         eh[10 + k] = ecnt16[8*k +: 8];
      end
   end

   always_comb begin
      case (phase_ff)
         PH_LHDR:  out_b = (cursor_ff < CW'(LOCAL_LEN)) ? lh[cursor_ff[4:0]] : 8'h00;
         PH_LNAME: out_b = name_q;
         PH_LDATA: out_b = data_q;
         PH_CHDR:  out_b = (cursor_ff < CW'(CENTRAL_LEN)) ? ch[cursor_ff[5:0]] : 8'h00;
         PH_CNAME: out_b = name_q;
         PH_END:   out_b = (cursor_ff < CW'(END_LEN)) ? eh[cursor_ff[4:0]] : 8'h00;
         default:  out_b = 8'h00;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      cursor_in      = cursor_ff;
      emit_entry_in  = emit_entry_ff;
      entry_count_in = entry_count_ff;
      data_count_in  = data_count_ff;
      name_fill_in   = name_fill_ff;
      name_mark_in   = name_mark_ff;
      crc_in         = crc_ff;
      bytes_in       = bytes_ff;
      cd_size_in     = cd_size_ff;
      cd_off_in      = cd_off_ff;
      error_in       = error_ff;
      cur_in         = cur_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      op_pop         = 1'b0;
      data_we        = 1'b0;
      name_we        = 1'b0;
      dir_we         = 1'b0;
      dir_wdata.crc    = crc_ff ^ ALL_ONES;
      dir_wdata.size   = data_count_ff;
      dir_wdata.start  = name_mark_ff;
      dir_wdata.len    = NLW'(name_fill_ff - name_mark_ff);
      dir_wdata.offset = bytes_ff;

      case (state_ff)
         ST_OP: begin
            if (op_valid && can_take) begin
               op_pop = 1'b1;
               case (op_data.kind)
                  OP_NAME: begin
                     if (busy || name_fill_ff >= NLW'(NAME_BYTES)) begin
                        error_in = 1'b1;
                     end else begin
                        name_we      = 1'b1;
                        name_fill_in = NLW'(name_fill_ff + NLW'(1));
                     end
                  end
                  OP_DATA: begin
                     if (busy || data_count_ff >= DW'(DATA_BYTES)) begin
                        error_in = 1'b1;
                     end else begin
                        data_we       = 1'b1;
                        data_count_in = DW'(data_count_ff + DW'(1));
                        crc_in        = crc_byte(crc_ff, op_data.value);
                     end
                  end
                  OP_END: begin
                     if (busy || entry_count_ff >= ECW'(MAX_ENTRIES)) begin
                        error_in = 1'b1;
                     end else begin
                        dir_we         = 1'b1;
                        cur_in         = dir_wdata;
                        emit_entry_in  = EA'(entry_count_ff);
                        entry_count_in = ECW'(entry_count_ff + ECW'(1));
                        name_mark_in   = name_fill_ff;
                        phase_in       = PH_LHDR;
                        cursor_in      = '0;
                     end
                  end
                  OP_FINISH: begin
                     if (busy) begin
                        error_in = 1'b1;
                     end else begin
                        emit_entry_in = '0;
                        cursor_in     = '0;
                        cd_off_in     = bytes_ff;
                        cd_size_in    = '0;
                        if (entry_count_ff == '0) begin
                           phase_in = PH_END;
                        end else begin
                           phase_in = PH_CHDR;
                           state_in = ST_DIRRD;
                        end
                     end
                  end
                  OP_PULL: begin
                     if (busy) begin
                        state_in = ST_PULL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PULL: begin
            rsp_valid_in         = 1'b1;
            rsp_in.out_byte      = out_b;
            rsp_in.archive_end   = last;
            rsp_in.dropped       = error_ff;
            bytes_in             = bytes_ff + 32'd1;
            cursor_in            = cursor_inc;
            if (phase_ff == PH_CHDR || phase_ff == PH_CNAME) begin
               cd_size_in = cd_size_ff + 32'd1;
            end
            state_in = ST_OP;
            if (last) begin
               phase_in       = PH_IDLE;
               cursor_in      = '0;
               emit_entry_in  = '0;
               entry_count_in = '0;
               data_count_in  = '0;
               name_fill_in   = '0;
               name_mark_in   = '0;
               crc_in         = ALL_ONES;
               bytes_in       = '0;
               error_in       = 1'b0;
            end else if (cursor_inc >= plen) begin
               cursor_in = '0;
               phase_in  = adv_phase;
               if (adv_clear) begin
                  data_count_in = '0;
                  crc_in        = ALL_ONES;
               end
               if (adv_entry) begin
                  emit_entry_in = EA'(emit_entry_ff + EA'(1));
               end
               state_in = adv_entry ? ST_DIRRD : ST_SKIP;
            end
         end
         ST_SKIP: begin
            state_in = ST_OP;
            if (busy && plen == '0) begin
               phase_in = adv_phase;
               if (adv_clear) begin
                  data_count_in = '0;
                  crc_in        = ALL_ONES;
               end
               if (adv_entry) begin
                  emit_entry_in = EA'(emit_entry_ff + EA'(1));
               end
               state_in = adv_entry ? ST_DIRRD : ST_SKIP;
            end
         end
         ST_DIRRD: state_in = ST_DIRLD;
         ST_DIRLD: begin
            cur_in   = dir_q;
            state_in = ST_OP;
         end
         default: state_in = ST_OP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_OP;
         phase_ff       <= PH_IDLE;
         cursor_ff      <= '0;
         emit_entry_ff  <= '0;
         entry_count_ff <= '0;
         data_count_ff  <= '0;
         name_fill_ff   <= '0;
         name_mark_ff   <= '0;
         crc_ff         <= ALL_ONES;
         bytes_ff       <= '0;
         error_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         cursor_ff      <= cursor_in;
         emit_entry_ff  <= emit_entry_in;
         entry_count_ff <= entry_count_in;
         data_count_ff  <= data_count_in;
         name_fill_ff   <= name_fill_in;
         name_mark_ff   <= name_mark_in;
         crc_ff         <= crc_in;
         bytes_ff       <= bytes_in;
         error_ff       <= error_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cd_size_ff <= cd_size_in;
      cd_off_ff  <= cd_off_in;
      cur_ff     <= cur_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ZSAW_ASSERT_NOW(a_pull_slot_free, clock, reset, state_ff == ST_PULL, !rsp_valid_ff, "output slot busy on pull")
   `ZSAW_ASSERT_NOW(a_entry_bound, clock, reset, 1'b1, entry_count_ff <= ECW'(MAX_ENTRIES), "entry count overflow")
   `ZSAW_ASSERT_NEXT(a_end_clears, clock, reset, state_ff == ST_PULL && last, phase_ff == PH_IDLE && entry_count_ff == '0 && !error_ff, "archive end did not clear")

endmodule

@@ rtl/core/zip_stored_archive_writer.sv @@
// Stored ZIP archive writer: name, data, end and finish requests build the archive,
// pull requests return it one byte at a time. A request is taken each cycle while the
// 4-deep queue has room. The back end pops each in its op state; a pull made while
// busy registers its byte in the pull state. Leaving a section takes the skip state,
// once more per empty section; a directory entry is read via the read and load states.
// Synchronous reset clears control state and the queue and restores the default stamps.
module zip_stored_archive_writer
   import zsaw_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int DATA_BYTES  = 4096,
   parameter int NAME_BYTES  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   logic [15:0] dos_time_ff;
   logic [15:0] dos_date_ff;
   logic        op_valid;
   op_type      op_data;
   logic        op_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         dos_time_ff <= '0;
         dos_date_ff <= DATE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DOS_TIME: dos_time_ff <= csr_wdata;
            CSR_DOS_DATE: dos_date_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   zsaw_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .op_valid(op_valid), .op_data(op_data), .op_pop(op_pop)
   );

   zsaw_back #(
      .MAX_ENTRIES(MAX_ENTRIES), .DATA_BYTES(DATA_BYTES), .NAME_BYTES(NAME_BYTES)
   ) u_back (
      .clock(clock), .reset(reset),
      .dos_time(dos_time_ff), .dos_date(dos_date_ff),
      .op_valid(op_valid), .op_data(op_data), .op_pop(op_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

@@ dv/zip_stored_archive_writer_test.sv @@
// Self-checking testbench for the stored ZIP archive writer.
// Depends on zsaw_pkg and zip_stored_archive_writer; a predictor checks pulls the table leaves open.
module zip_stored_archive_writer_test;
   import zsaw_pkg::*;

   localparam int N_ENTRIES  = 16;
   localparam int N_DATA     = 4096;
   localparam int N_NAME     = 1024;
   localparam int SETTLE     = 40;
   localparam int CYCLE_CAP  = 400000;
   localparam int RAND_ITEMS = 960;

   typedef enum logic [2:0] {
      SEC_IDLE, SEC_LHDR, SEC_LNAME, SEC_LDATA, SEC_CHDR, SEC_CNAME, SEC_END
   } section_type;

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type exp;
   } request_type;

   typedef struct {
      logic [2:0] mode;
      logic [7:0] val;
      int         reps;
      bit         typed;
      rsp_type    exp;
   } table_row_type;

   logic    clock, reset;
   logic    csr_we, csr_index;
   logic [15:0] csr_wdata;
   logic    req_valid, req_stall;
   req_type req_data;
   logic    rsp_valid, rsp_stall;
   rsp_type rsp_data;

   zip_stored_archive_writer DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // archive predictor state
   logic [7:0]  data_mem [N_DATA];
   logic [7:0]  name_mem [N_NAME];
   logic [31:0] ent_crc [N_ENTRIES], ent_size [N_ENTRIES], ent_nstart [N_ENTRIES];
   logic [31:0] ent_nlen [N_ENTRIES], ent_off [N_ENTRIES];
   logic [31:0] crc_acc, data_cnt, name_cnt, ent_cnt, out_cnt, cursor, cur_ent;
   section_type section;
   bit          sticky_err;
   logic [15:0] stamp_time, stamp_date;
   logic [7:0]  hdr_buf [46];

   request_type requests[$];
   rsp_type     pending_bytes[$];
   request_type cur_req;
   int          failures, cycles, req_gap, stall_left;
   bit          calm;

   function automatic void clear_archive();
      crc_acc = ALL_ONES;
      data_cnt = 0; name_cnt = 0; ent_cnt = 0; out_cnt = 0;
      cursor = 0; cur_ent = 0; sticky_err = 0;
      section = SEC_IDLE;
      for (int i = 0; i < N_ENTRIES; i++) begin
         ent_crc[i] = 0; ent_size[i] = 0; ent_nstart[i] = 0; ent_nlen[i] = 0; ent_off[i] = 0;
      end
   endfunction

   function automatic void put_le(int at, logic [31:0] v, int n);
      for (int i = 0; i < n; i++) hdr_buf[at + i] = v[8*i +: 8];
   endfunction

   function automatic int unsigned section_len();
      int unsigned e;
      e = cur_ent < N_ENTRIES ? cur_ent : 0;
      case (section)
         SEC_LHDR:  return LOCAL_LEN;
         SEC_LNAME: return ent_nlen[e[3:0]];
         SEC_LDATA: return ent_size[e[3:0]];
         SEC_CHDR:  return CENTRAL_LEN;
         SEC_CNAME: return ent_nlen[e[3:0]];
         SEC_END:   return END_LEN;
         default:   return 0;
      endcase
   endfunction

   function automatic void next_section();
      cursor = 0;
      case (section)
         SEC_LHDR:  section = SEC_LNAME;
         SEC_LNAME: section = SEC_LDATA;
         SEC_LDATA: begin
            section = SEC_IDLE;
            data_cnt = 0;
            crc_acc = ALL_ONES;
         end
         SEC_CHDR:  section = SEC_CNAME;
         SEC_CNAME: begin
            cur_ent++;
            section = cur_ent < ent_cnt ? SEC_CHDR : SEC_END;
         end
         default:   section = SEC_IDLE;
      endcase
   endfunction

   function automatic logic [7:0] archive_byte();
      int unsigned e, c, k;
      logic [31:0] csize;
      e = cur_ent < N_ENTRIES ? cur_ent : 0;
      c = cursor;
      csize = 0;
      for (int i = 0; i < 46; i++) hdr_buf[i] = 8'd0;
      case (section)
         SEC_LHDR: begin
            put_le(0, SIG_LOCAL, 4); put_le(4, 32'(ZIP_VERSION), 2);
            put_le(10, 32'(stamp_time), 2); put_le(12, 32'(stamp_date), 2);
            put_le(14, ent_crc[e[3:0]], 4); put_le(18, ent_size[e[3:0]], 4);
            put_le(22, ent_size[e[3:0]], 4); put_le(26, ent_nlen[e[3:0]], 2);
            return c < LOCAL_LEN ? hdr_buf[c[5:0]] : 8'd0;
         end
         SEC_LNAME, SEC_CNAME: begin
            k = ent_nstart[e[3:0]] + c;
            return k < N_NAME ? name_mem[k[9:0]] : 8'd0;
         end
         SEC_LDATA: return c < N_DATA ? data_mem[c[11:0]] : 8'd0;
         SEC_CHDR: begin
            put_le(0, SIG_CENTRAL, 4); put_le(4, 32'(ZIP_VERSION), 2);
            put_le(6, 32'(ZIP_VERSION), 2);
            put_le(12, 32'(stamp_time), 2); put_le(14, 32'(stamp_date), 2);
            put_le(16, ent_crc[e[3:0]], 4); put_le(20, ent_size[e[3:0]], 4);
            put_le(24, ent_size[e[3:0]], 4); put_le(28, ent_nlen[e[3:0]], 2);
            put_le(42, ent_off[e[3:0]], 4);
            return c < CENTRAL_LEN ? hdr_buf[c[5:0]] : 8'd0;
         end
         SEC_END: begin
            for (k = 0; k < ent_cnt && k < N_ENTRIES; k++)
               csize += CENTRAL_LEN + ent_nlen[k[3:0]];
            put_le(0, SIG_END, 4); put_le(8, ent_cnt, 2); put_le(10, ent_cnt, 2);
            put_le(12, csize, 4); put_le(16, out_cnt - c - csize, 4);
            return c < END_LEN ? hdr_buf[c[5:0]] : 8'd0;
         end
         default: return 8'd0;
      endcase
   endfunction

   function automatic bit archive_step(req_type r, output rsp_type o);
      bit busy;
      logic [31:0] start;
      logic [31:0] prev;
      busy = section != SEC_IDLE;
      o = '0;
      if (r.mode <= MODE_FINISH && busy) begin
         sticky_err = 1;
         return 0;
      end
      case (r.mode)
         MODE_NAME: begin
            if (name_cnt >= N_NAME) sticky_err = 1;
            else begin
               name_mem[name_cnt[9:0]] = r.in_byte;
               name_cnt++;
            end
            return 0;
         end
         MODE_DATA: begin
            if (data_cnt >= N_DATA) sticky_err = 1;
            else begin
               data_mem[data_cnt[11:0]] = r.in_byte;
               data_cnt++;
               crc_acc ^= {24'd0, r.in_byte};
               for (int i = 0; i < 8; i++)
                  crc_acc = crc_acc[0] ? (crc_acc >> 1) ^ CRC_POLY : crc_acc >> 1;
            end
            return 0;
         end
         MODE_END: begin
            if (ent_cnt >= N_ENTRIES) begin
               sticky_err = 1;
               return 0;
            end
            prev = ent_cnt - 32'd1;
            start = ent_cnt == 0 ? 0 : ent_nstart[prev[3:0]] + ent_nlen[prev[3:0]];
            ent_crc[ent_cnt[3:0]] = crc_acc ^ ALL_ONES;
            ent_size[ent_cnt[3:0]] = data_cnt;
            ent_nstart[ent_cnt[3:0]] = start;
            ent_nlen[ent_cnt[3:0]] = name_cnt - start;
            ent_off[ent_cnt[3:0]] = out_cnt;
            cur_ent = ent_cnt;
            ent_cnt++;
            section = SEC_LHDR;
            cursor = 0;
            return 0;
         end
         MODE_FINISH: begin
            cur_ent = 0;
            cursor = 0;
            section = ent_cnt == 0 ? SEC_END : SEC_CHDR;
            return 0;
         end
         MODE_PULL: begin
            if (!busy) return 0;
            o.out_byte = archive_byte();
            o.dropped = sticky_err;
            out_cnt++;
            cursor++;
            if (section == SEC_END && cursor >= END_LEN) begin
               o.archive_end = 1'b1;
               clear_archive();
               return 1;
            end
            if (cursor >= section_len()) begin
               next_section();
               while (section != SEC_IDLE && section_len() == 0) next_section();
            end
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got, want, cycles);
      failures++;
   endtask

   function automatic int pick_gap();
      int r;
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   task automatic add(logic [2:0] mode, logic [7:0] val);
      request_type q;
      q.r.mode = mode;
      q.r.in_byte = val;
      q.typed = 0;
      q.exp = '0;
      requests.push_back(q);
   endtask

   // request stream with dropped/ignored items sprinkled between pulls
   task automatic add_pulls(int n);
      for (int i = 0; i < n; i++) begin
         add(MODE_PULL, 8'($urandom_range(0, 255)));
         if (i < n - 1 && $urandom_range(0, 29) == 0) begin
            if ($urandom_range(0, 1))
               add(3'($urandom_range(MODE_NAME, MODE_FINISH)), 8'($urandom_range(0, 255)));
            else
               add(3'(MODE_PULL + $urandom_range(1, 3)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic add_random_archive(ref int count);
      int n_ent, nl, dl, dir_len;
      bit open_tail;
      n_ent = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4);
      open_tail = $urandom_range(0, 7) == 0;
      dir_len = 0;
      for (int e = 0; e < n_ent + open_tail; e++) begin
         nl = $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 8);
         dl = $urandom_range(0, 19) == 0 ? $urandom_range(60, 120) : $urandom_range(0, 16);
         if ($urandom_range(0, 9) == 0) add(MODE_PULL, 8'h00);
         for (int i = 0; i < nl; i++) add(MODE_NAME, 8'($urandom_range(0, 255)));
         for (int i = 0; i < dl; i++) add(MODE_DATA, 8'($urandom_range(0, 255)));
         count += nl + dl;
         if (e < n_ent) begin
            add(MODE_END, 8'($urandom_range(0, 255)));
            add_pulls(LOCAL_LEN + nl + dl);
            dir_len += CENTRAL_LEN + nl;
            count += 1 + LOCAL_LEN + nl + dl;
         end
      end
      add(MODE_FINISH, 8'($urandom_range(0, 255)));
      add_pulls(dir_len + END_LEN);
      count += 1 + dir_len + END_LEN;
   endtask

   task automatic load_directed();
      table_row_type rows[$];
      request_type q;
      rows = '{
         '{MODE_PULL,   8'h00, 1,  0, '0},
         '{3'd7,        8'hFF, 1,  0, '0},
         '{MODE_NAME,   8'h00, 1,  0, '0},
         '{MODE_NAME,   8'hFF, 1,  0, '0},
         '{MODE_DATA,   8'h00, 1,  0, '0},
         '{MODE_DATA,   8'hFF, 1,  0, '0},
         '{MODE_END,    8'h00, 1,  0, '0},
         '{MODE_PULL,   8'h00, 1,  1, '{8'h50, 1'b0, 1'b0}},
         '{MODE_PULL,   8'h00, 1,  1, '{8'h4B, 1'b0, 1'b0}},
         '{MODE_PULL,   8'h00, 1,  1, '{8'h03, 1'b0, 1'b0}},
         '{MODE_PULL,   8'h00, 1,  1, '{8'h04, 1'b0, 1'b0}},
         '{MODE_PULL,   8'h00, 1,  1, '{8'h14, 1'b0, 1'b0}},
         '{MODE_DATA,   8'h55, 1,  0, '0},
         '{MODE_PULL,   8'h00, 29, 0, '0},
         '{MODE_FINISH, 8'h00, 1,  0, '0},
         '{MODE_PULL,   8'h00, 1,  1, '{8'h50, 1'b0, 1'b1}},
         '{MODE_PULL,   8'h00, 69, 0, '0},
         '{MODE_FINISH, 8'h00, 1,  0, '0},
         '{MODE_PULL,   8'h00, 1,  1, '{8'h50, 1'b0, 1'b0}},
         '{MODE_PULL,   8'h00, 1,  1, '{8'h4B, 1'b0, 1'b0}},
         '{MODE_PULL,   8'h00, 1,  1, '{8'h05, 1'b0, 1'b0}},
         '{MODE_PULL,   8'h00, 1,  1, '{8'h06, 1'b0, 1'b0}},
         '{MODE_PULL,   8'h00, 17, 0, '0},
         '{MODE_PULL,   8'h00, 1,  1, '{8'h00, 1'b1, 1'b0}}
      };
      foreach (rows[i]) begin
         for (int n = 0; n < rows[i].reps; n++) begin
            q.r.mode = rows[i].mode;
            q.r.in_byte = rows[i].val;
            q.typed = rows[i].typed;
            q.exp = rows[i].exp;
            requests.push_back(q);
         end
      end
   endtask

   task automatic csr_write(logic idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DOS_TIME) stamp_time = val;
      else stamp_date = val;
   endtask

   task automatic settle();
      while (requests.size() != 0 || req_valid || pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // request side
   always @(posedge clock) begin
      rsp_type o;
      if (req_valid && req_stall === 1'b0) begin
         if (archive_step(cur_req.r, o)) begin
            if (cur_req.typed) o = cur_req.exp;
            pending_bytes.push_back(o);
         end
      end
      if (!(req_valid && req_stall !== 1'b0)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (!reset && requests.size() != 0) begin
            cur_req = requests.pop_front();
            req_data <= cur_req.r;
            req_valid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch("unexpected byte", 32'(rsp_data), 32'd0);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               report_mismatch("out_byte", 32'(rsp_data.out_byte), 32'(want.out_byte));
            if (rsp_data.archive_end !== want.archive_end)
               report_mismatch("archive_end", 32'(rsp_data.archive_end),
                               32'(want.archive_end));
            if (rsp_data.dropped !== want.dropped)
               report_mismatch("dropped", 32'(rsp_data.dropped), 32'(want.dropped));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= stall_left > 0;
      end
   end

   initial begin
      int count;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_DOS_TIME;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      failures = 0; cycles = 0; req_gap = 0; stall_left = 0; calm = 0;
      stamp_time = 16'd0;
      stamp_date = DATE_RESET;
      clear_archive();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      load_directed();
      settle();

      count = 0;
      for (int p = 0; p < 3; p++) begin
         if (p == 0) begin
            csr_write(CSR_DOS_TIME, 16'hFFFF);
            csr_write(CSR_DOS_DATE, 16'hFFFF);
         end else if (p == 1) begin
            csr_write(CSR_DOS_TIME, 16'h0000);
            csr_write(CSR_DOS_DATE, 16'h0000);
         end else begin
            csr_write(CSR_DOS_TIME, 16'($urandom_range(0, 16'hFFFF)));
            csr_write(CSR_DOS_DATE, 16'($urandom_range(0, 16'hFFFF)));
         end
         while (count < RAND_ITEMS * (p + 1) / 3) add_random_archive(count);
         settle();
      end

      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
